// ----- rtl/core/dlcd_pkg.sv -----
// shared constants and the digit segment table for the six-digit lcd writer
// no dependencies; used by dlcd_div10 and decimal_lcd_digit_writer
package dlcd_pkg;

  // default number of digit positions on the glass
  localparam int NUM_DIGITS_DEF = 6;
  // pattern nibbles per digit, one per common line
  localparam int GROUPS = 4;
  // display register stride between common lines
  localparam int REG_STRIDE = 5;
  // reciprocal of ten, scaled by 2^35
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;
  // ascii digit codes
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  // item kinds carried in tuser
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_NUM  = 1'b1;

  // four-nibble segment pattern of a decimal digit
  function automatic logic [15:0] digit_pattern(input logic [3:0] d);
    logic [15:0] p;
    case (d)
      4'd0:    p = 16'h1551;
      4'd1:    p = 16'h0110;
      4'd2:    p = 16'h1E11;
      4'd3:    p = 16'h1B11;
      4'd4:    p = 16'h0B50;
      4'd5:    p = 16'h1B41;
      4'd6:    p = 16'h1F41;
      4'd7:    p = 16'h0111;
      4'd8:    p = 16'h1F51;
      4'd9:    p = 16'h1B51;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/dlcd_div10.sv -----
// divide-by-ten unit: reciprocal multiply, registered product
// depends on dlcd_pkg for the reciprocal constant
module dlcd_div10 (
  input  logic        clk,
  input  logic        load,
  input  logic [30:0] value,
  output logic [27:0] quot,
  output logic [3:0]  digit
);
  import dlcd_pkg::*;

  logic [30:0] value_q;
  logic [62:0] prod;
  logic [30:0] quot_x10;

  // capture the dividend and its scaled product
  always_ff @(posedge clk) begin
    if (load) begin
      value_q <= value;
      prod    <= 63'(value) * 63'(RECIP10);
    end
  end

  // quotient from the product, remainder by shift-add back-multiply
  assign quot     = prod[62:RECIP_SHIFT];
  assign quot_x10 = 31'({3'b000, quot} << 3) + 31'({3'b000, quot} << 1);
  assign digit    = 4'(value_q - quot_x10);

endmodule

// ----- rtl/core/decimal_lcd_digit_writer.sv -----
// six-digit segment lcd writer: display memory read-modify-write sequencer
// depends on dlcd_pkg and dlcd_div10
//
//   channel | dir | handshake          | word contents
//   s_*     | in  | s_tvalid/s_tready  | op (tuser), char_code, position, number (tdata)
//   m_*     | out | m_tvalid/m_tready  | reg_index, reg_data (tdata), last (tlast)
//
// one item is handled at a time; s_tready is high only while the sequencer is idle
// each display byte is a memory read, then a merge and write-back
// a character item is accepted, then writes four bytes; a number item, per digit,
// runs the divide-by-ten multiply (MUL, REM), then writes four bytes, up to NUM_DIGITS digits
// a stalled output holds the write-back state until the output register frees
// rst clears the sequencer, the output valid and the per-entry valid bits,
// so display memory reads as zero right after reset with no clearing pass
module decimal_lcd_digit_writer #(
  parameter int NUM_DIGITS = dlcd_pkg::NUM_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // char_code[7:0], position[10:8], number[41:11], zeros
  input  logic [0:0]  s_tuser,  // op[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // reg_index[4:0], reg_data[12:5], zeros
  output logic        m_tlast
);
  import dlcd_pkg::*;

  localparam int COLS  = (NUM_DIGITS + 1) / 2;
  localparam int DEPTH = GROUPS * COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_REM  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;

  logic [2:0]  state;
  logic        op_num;
  logic [2:0]  pos;
  logic [1:0]  grp;
  logic [30:0] num;
  logic [15:0] last_pattern;

  logic [7:0]  mem [DEPTH];
  logic [DEPTH-1:0] mem_valid;
  logic [7:0]  rd_data;
  logic        rd_valid;

  logic        accept;
  logic [7:0]  in_char;
  logic [2:0]  in_pos;
  logic [30:0] in_num;
  logic        in_op;
  logic        in_digit;
  logic        in_pos_ok;

  logic [2:0]  pos_m1;
  logic [1:0]  col;
  logic        hi_nib;
  logic [AW-1:0] addr;
  logic [3:0]  nib;
  logic [7:0]  old_byte;
  logic [7:0]  new_byte;
  logic        out_free;
  logic        wr_go;
  logic        is_last;

  logic        div_load;
  logic [27:0] div_quot;
  logic [3:0]  div_digit;

  // input word unpacking
  assign in_op     = s_tuser[0];
  assign in_char   = s_tdata[7:0];
  assign in_pos    = s_tdata[10:8];
  assign in_num    = s_tdata[41:11];
  assign in_digit  = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
  assign in_pos_ok = (in_pos >= 3'd1) && (32'(in_pos) <= 32'(NUM_DIGITS));
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  // address and nibble selection for the current byte
  assign pos_m1   = pos - 3'd1;
  assign col      = pos_m1[2:1];
  assign hi_nib   = pos_m1[0];
  assign addr     = AW'(32'(grp) * COLS + 32'(col));
  assign nib      = last_pattern[4*grp +: 4];
  assign old_byte = rd_valid ? rd_data : 8'h00;
  assign new_byte = hi_nib ? {nib, old_byte[3:0]} : {old_byte[7:4], nib};
  assign out_free = !m_tvalid || m_tready;
  assign wr_go    = (state == ST_WR) && out_free;
  assign is_last  = (grp == 2'd3) && (!op_num || (pos == 3'd1) || (num == 31'd0));
  assign div_load = (state == ST_MUL);

  dlcd_div10 u_div10 (
    .clk   (clk),
    .load  (div_load),
    .value (num),
    .quot  (div_quot),
    .digit (div_digit)
  );

  // display memory, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      rd_data <= mem[addr];
    end
    if (wr_go) begin
      mem[addr] <= new_byte;
    end
  end

  // per-entry valid bits stand in for the all-zero reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (state == ST_RD) begin
        rd_valid <= mem_valid[addr];
      end
      if (wr_go) begin
        mem_valid[addr] <= 1'b1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      last_pattern <= 16'h0000;
      op_num       <= OP_CHAR;
      grp          <= 2'd0;
      pos          <= 3'd1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_num <= in_op;
            grp    <= 2'd0;
            if (in_op == OP_CHAR) begin
              if (in_digit) begin
                last_pattern <= digit_pattern(4'(in_char - CHAR_ZERO));
              end
              pos <= in_pos;
              if (in_pos_ok) begin
                state <= ST_RD;
              end
            end else begin
              pos <= 3'(NUM_DIGITS);
              num <= in_num;
              if (in_num != 31'd0) begin
                state <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          state <= ST_REM;
        end
        ST_REM: begin
          last_pattern <= digit_pattern(div_digit);
          num          <= {3'b000, div_quot};
          state        <= ST_RD;
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          if (out_free) begin
            grp <= grp + 2'd1;
            if (grp != 2'd3) begin
              state <= ST_RD;
            end else if (is_last) begin
              state <= ST_IDLE;
            end else begin
              pos   <= pos - 3'd1;
              state <= ST_MUL;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (wr_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      m_tdata <= {3'b000, new_byte, 5'(32'(grp) * REG_STRIDE + 32'(col))};
      m_tlast <= is_last;
    end
  end

  // checks
  a_rd_then_wr: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD |=> state == ST_WR)
    else $error("read cycle not followed by write-back");

  a_wr_loads_out: assert property (@(posedge clk) disable iff (rst)
    wr_go |=> m_tvalid)
    else $error("write-back did not present an output word");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_REM |-> div_digit <= 4'd9)
    else $error("remainder of divide by ten out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD |-> (pos >= 3'd1) && (32'(pos) <= 32'(NUM_DIGITS)))
    else $error("memory access at a position off the glass");

endmodule
